[rtl/core/cbbq_pkg.sv]
// Shared types, constants and helper functions of the credit batched byte queue.
`default_nettype none

package cbbq_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned BATCH_MAX   = 16;

  localparam int unsigned PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BATCH_W  = $clog2(BATCH_MAX + 1);
  localparam int unsigned CREDIT_W = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned SUM_W0 = (CNT_W > BATCH_W) ? CNT_W : BATCH_W;
  localparam int unsigned SUM_W  = (SUM_W0 > CREDIT_W) ? SUM_W0 : CREDIT_W;

  localparam logic [BYTE_W-1:0] FLUSH_CODE = 8'hff;
  localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0d;

  localparam logic [CFG_W-1:0]    MSG_CODE_RST     = 8'd83;
  localparam logic [CREDIT_W-1:0] INIT_CREDIT_RST  = 8'd16;

  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_CODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_CREDIT = 1'b1;

  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_CREDIT  = 1'b1;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_HI,
    ST_LO,
    ST_CR,
    ST_REJECT
  } state_e;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] sound_byte;
    logic [7:0]        free_count;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_char;
    logic              last;
  } out_item_t;

  // Command bundle from the controller to the queue storage.
  typedef struct packed {
    logic               push;
    logic               flush;
    logic [BYTE_W-1:0]  data;
    logic               take;
    logic [BATCH_W-1:0] take_n;
    logic               rd;
  } q_cmd_t;

  // Entry count after an enqueue step; a flush leaves only the flush byte.
  function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] count,
                                                  input logic push,
                                                  input logic flush);
    logic [CNT_W-1:0] res;
    if (flush) begin
      res = CNT_W'(1);
    end else if (push) begin
      res = count + CNT_W'(1);
    end else begin
      res = count;
    end
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] c;
    case (nib)
      4'h0: c = "0";
      4'h1: c = "1";
      4'h2: c = "2";
      4'h3: c = "3";
      4'h4: c = "4";
      4'h5: c = "5";
      4'h6: c = "6";
      4'h7: c = "7";
      4'h8: c = "8";
      4'h9: c = "9";
      4'ha: c = "A";
      4'hb: c = "B";
      4'hc: c = "C";
      4'hd: c = "D";
      4'he: c = "E";
      default: c = "F";
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/credit_batched_byte_queue.sv]
// Top level of the credit batched byte queue: command port, batch sequencer and registers.
`default_nettype none

// A byte queue that forwards sound codes to a remote player under credit control.
// A command is taken on a clock edge where start is high and busy is low.
// An enqueue command adds one byte (the byte 0xff first empties the queue and
// restores the credit to initial_credit); a credit command loads the remote
// free-slot count. After either, when the queue holds bytes and the credit
// covers a batch of n = min(count, 16) bytes, the batch is sent as one
// transfer per cycle on res_o, each marked by res_valid_o: the message code,
// two uppercase hex characters per byte, then a carriage return, with last
// set on the final transfer. Transfers cannot be held off by the receiver.
// An enqueue into a full queue (255 entries, one slot kept free) yields a
// single reject transfer instead. After the accepting edge busy stays high
// while the sequencer sends the message code, the hex characters of each
// byte and the carriage return, or the reject transfer; a command that
// sends nothing keeps busy low. The length of a batch is set by the one
// character per cycle output and the single read port of the byte memory,
// which is read once per byte during the batch.
module credit_batched_byte_queue (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start,
  output logic                                busy,
  input  cbbq_pkg::in_item_t                  in_i,
  output logic                                res_valid_o,
  output cbbq_pkg::out_item_t                 res_o,
  input  wire                                 cfg_we_i,
  input  wire  [cbbq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [cbbq_pkg::CFG_W-1:0]          cfg_wdata_i
);
  import cbbq_pkg::*;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     msg_code_q;
  logic [CREDIT_W-1:0]  init_credit_q;
  logic [CREDIT_W-1:0]  credit_q, credit_d, credit_n;
  logic [BATCH_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]     count, count_n;
  logic [BYTE_W-1:0]    rd_data;
  logic [SUM_W-1:0]     batch_w;
  logic [BATCH_W-1:0]   batch_n;
  logic                 accept, full, reject, push, flush, send;
  q_cmd_t               q_cmd;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_code_q    <= MSG_CODE_RST;
      init_credit_q <= INIT_CREDIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MESSAGE_CODE:   msg_code_q    <= cfg_wdata_i;
        REG_INITIAL_CREDIT: init_credit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Command decode. The whole decision is made at the accepting edge: the
  // entry count and credit after the command give the batch size, and the
  // credit and count are charged for the batch right away. The bytes are
  // then read out one by one while the sequencer runs.
  assign accept = start && !busy;
  assign full   = (count >= CNT_W'(QUEUE_DEPTH - 1));
  assign reject = (in_i.func == FUNC_ENQUEUE) && full;
  assign push   = (in_i.func == FUNC_ENQUEUE) && !full;
  assign flush  = push && (in_i.sound_byte == FLUSH_CODE);

  always_comb begin
    count_n = next_count(count, push, flush);
    if (in_i.func == FUNC_CREDIT) begin
      credit_n = in_i.free_count;
    end else if (flush) begin
      credit_n = init_credit_q;
    end else begin
      credit_n = credit_q;
    end
    if (SUM_W'(count_n) < SUM_W'(BATCH_MAX)) begin
      batch_w = SUM_W'(count_n);
    end else begin
      batch_w = SUM_W'(BATCH_MAX);
    end
    batch_n = batch_w[BATCH_W-1:0];
    send    = !reject && (count_n != '0) && (SUM_W'(credit_n) >= batch_w);
  end

  // Batch sequencer. The read for the first byte goes out with the message
  // code; each further read goes out with the low nibble of the byte before,
  // so the registered read data is ready for the next high nibble.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    credit_d    = credit_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_CHAR, out_char: '0, last: 1'b0};
    q_cmd       = '0;
    q_cmd.data  = in_i.sound_byte;
    q_cmd.take_n = batch_n;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (reject) begin
            state_d = ST_REJECT;
          end else begin
            q_cmd.push  = push;
            q_cmd.flush = flush;
            q_cmd.take  = send;
            if (send) begin
              credit_d = CREDIT_W'(SUM_W'(credit_n) - batch_w);
              rem_d    = batch_n;
              state_d  = ST_CODE;
            end else begin
              credit_d = credit_n;
            end
          end
        end
      end
      ST_CODE: begin
        res_valid_o    = 1'b1;
        res_o.out_char = msg_code_q;
        q_cmd.rd       = 1'b1;
        state_d        = ST_HI;
      end
      ST_HI: begin
        res_valid_o    = 1'b1;
        res_o.out_char = hex_char(rd_data[7:4]);
        state_d        = ST_LO;
      end
      ST_LO: begin
        res_valid_o    = 1'b1;
        res_o.out_char = hex_char(rd_data[3:0]);
        rem_d          = rem_q - BATCH_W'(1);
        if (rem_q == BATCH_W'(1)) begin
          state_d = ST_CR;
        end else begin
          q_cmd.rd = 1'b1;
          state_d  = ST_HI;
        end
      end
      ST_CR: begin
        res_valid_o    = 1'b1;
        res_o.out_char = CR_CHAR;
        res_o.last     = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_REJECT: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_REJECT;
        res_o.last  = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      credit_q <= INIT_CREDIT_RST;
      rem_q    <= '0;
    end else begin
      state_q  <= state_d;
      credit_q <= credit_d;
      rem_q    <= rem_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  cbbq_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (q_cmd),
    .count_o   (count),
    .rd_data_o (rd_data)
  );

  // The memory is never written and read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_cmd.push && q_cmd.rd))
    else $error("queue written and read in the same cycle");

  // One slot always stays free.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(QUEUE_DEPTH - 1))
    else $error("entry count beyond capacity");

  // A rejected enqueue gives its reject transfer in the very next cycle.
  a_reject_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && reject |=> res_valid_o && (res_o.kind == KIND_REJECT) && res_o.last)
    else $error("reject transfer missing");

  // After the final transfer of a command the block is ready again.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !busy)
    else $error("busy after final transfer");

endmodule

`default_nettype wire

[rtl/core/cbbq_queue.sv]
// Queue storage: byte memory with read and write pointers and the entry count.
`default_nettype none

module cbbq_queue (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  cbbq_pkg::q_cmd_t                  cmd_i,
  output logic [cbbq_pkg::CNT_W-1:0]        count_o,
  output logic [cbbq_pkg::BYTE_W-1:0]       rd_data_o
);
  import cbbq_pkg::*;

  logic [BYTE_W-1:0] mem [QUEUE_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_addr;
  logic [CNT_W-1:0]  count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // A flush restarts both pointers, so the flush byte lands at entry zero.
  assign wr_addr = cmd_i.flush ? '0 : wr_ptr_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.flush) begin
      rd_ptr_d = '0;
    end
    if (cmd_i.push) begin
      wr_ptr_d = ptr_inc(wr_addr);
    end
    if (cmd_i.rd) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    count_d = next_count(count_q, cmd_i.push, cmd_i.flush);
    if (cmd_i.take) begin
      count_d = count_d - CNT_W'(cmd_i.take_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= cmd_i.data;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  assign count_o   = count_q;
  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
